// File: hdl/elfh_pkg.sv
// Shared types, codes and constants for the ELF SysV hash table builder.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package elfh_pkg;

    // Field widths fixed by the item formats
    localparam int unsigned HASH_W  = 28;
    localparam int unsigned SLOT_W  = 13;
    localparam int unsigned WORD_W  = 17;
    localparam int unsigned TOTAL_W = 16;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned STEP_W  = 5;

    // Request function codes
    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_END   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_START = 2'd3;

    // Result kind codes
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_CHAIN  = 2'd1;
    localparam logic [1:0] KIND_HEAD   = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd16;

    // Stepped prime table for the bucket count
    localparam int unsigned PRIME_N = 16;
    localparam logic [COUNT_W-1:0] PRIMES [PRIME_N] = '{
        16'd1, 16'd3, 16'd17, 16'd37, 16'd67, 16'd97, 16'd131, 16'd197,
        16'd263, 16'd521, 16'd1031, 16'd2053, 16'd4099, 16'd8209,
        16'd16411, 16'd32771
    };

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        name_byte;
        logic [SLOT_W-1:0] read_slot;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] word_value;
        logic [WORD_W-1:0] chain_total;
        logic [HASH_W-1:0] hash_value;
        logic [SLOT_W-1:0] slot_used;
        logic              error_flag;
    } result_t;

    // Request to the remainder unit
    typedef struct packed {
        logic               go;
        logic [HASH_W-1:0]  dividend;
        logic [COUNT_W-1:0] divisor;
    } mod_req_t;

    // Control toward the bucket store
    typedef struct packed {
        logic clear_go;
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

    // Pick the largest table prime reached by total, capped at depth
    function automatic logic [COUNT_W-1:0] pick_buckets(
        input logic [TOTAL_W-1:0] total,
        input int unsigned        depth
    );
        logic [COUNT_W-1:0] n;
        n = PRIMES[0];
        for (int i = 1; i < PRIME_N; i++) begin
            if ({16'd0, total} >= 32'(PRIMES[i]) && 32'(PRIMES[i]) <= depth)
            begin
                n = PRIMES[i];
            end
        end
        return n;
    endfunction

endpackage

// File: hdl/elfh_mod_unit.sv
// Iterative remainder unit: hash modulo bucket count, one quotient bit per cycle.
// Depends on elfh_pkg for widths and the request struct.
module elfh_mod_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  elfh_pkg::mod_req_t                  req,
    output logic                                done,
    output logic [elfh_pkg::COUNT_W-1:0]        remainder
);

    logic [elfh_pkg::COUNT_W-1:0] rem_reg, rem_next;
    logic [elfh_pkg::HASH_W-1:0]  dvd_reg, dvd_next;
    logic [elfh_pkg::COUNT_W-1:0] dvs_reg, dvs_next;
    logic [elfh_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [elfh_pkg::COUNT_W:0]   trial;

    // Shift in the next dividend bit and compare against the divisor
    assign trial = {rem_reg, dvd_reg[elfh_pkg::HASH_W-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = elfh_pkg::STEP_W'(elfh_pkg::HASH_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Subtract when the partial remainder reaches the divisor
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = elfh_pkg::COUNT_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[elfh_pkg::COUNT_W-1:0];
            end
            dvd_next = {dvd_reg[elfh_pkg::HASH_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/elfh_bucket_store.sv
// Bucket head memory with a clearing sweep over the active buckets.
// Depends on elfh_pkg for the control struct and word width.
module elfh_bucket_store #(
    parameter int unsigned AW = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  elfh_pkg::store_ctl_t              ctl,
    input  logic [AW-1:0]                     addr,
    input  logic [elfh_pkg::WORD_W-1:0]       wdata,
    input  logic [elfh_pkg::COUNT_W-1:0]      clear_count,
    output logic [elfh_pkg::WORD_W-1:0]       rdata,
    output logic                              busy
);

    localparam int unsigned DEPTH = 1 << AW;

    logic [elfh_pkg::WORD_W-1:0] mem [DEPTH];
    logic [elfh_pkg::WORD_W-1:0] rdata_reg;
    logic                        sweep_reg, sweep_next;
    logic [AW-1:0]               sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]               sweep_last_reg, sweep_last_next;

    // Advance the sweep one bucket per cycle; out of reset clear bucket zero
    always_comb
    begin
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        if (ctl.clear_go)
        begin
            sweep_next      = 1'b1;
            sweep_addr_next = '0;
            sweep_last_next = AW'(clear_count - 1'b1);
        end
        else if (sweep_reg)
        begin
            if (sweep_addr_reg == sweep_last_reg)
            begin
                sweep_next = 1'b0;
            end
            else
            begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            sweep_last_reg <= '0;
        end
        else
        begin
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
        end
    end

    // Single write port shared by the sweep and head updates
    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            mem[sweep_addr_reg] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = sweep_reg;

endmodule

// File: hdl/elf_sysv_hash_table_builder_top.sv
// Top level of the ELF SysV hash table builder: sequencer, hash and registers.
// Depends on elfh_pkg, elfh_mod_unit and elfh_bucket_store.
//
// Usage:
//   Requests arrive on cmd and are taken at a clock edge with start high and
//   busy low. Results appear on result for exactly one cycle with done high;
//   the receiver cannot stall, so each result must be taken in that cycle.
//   symbol_total is written via cfg_valid/cfg_ready/cfg_data; cfg_ready is
//   always high. Write it only while no request is in flight (not enforced).
// Sequence:
//   Name byte: no result, busy stays low.
//   Read head: result via ST_RDOUT; straight from ST_IDLE if out of range.
//   End of name: the 28-step remainder unit, then the bucket read (ST_FETCH)
//   and write back (ST_UPD); when the symbol overflows the table the result
//   comes from ST_DIV without them. busy drops in the cycle the result shows.
//   Start: header on the next cycle; busy then stays high while the memory
//   sweep zeroes the active buckets.
// Reset:
//   Table acts as one empty bucket; busy stays high while bucket zero is
//   cleared. symbol_total resets to 16.
module elf_sysv_hash_table_builder_top #(
    parameter int unsigned BUCKET_DEPTH = 4099,
    parameter int unsigned SYMBOL_LIMIT = 65535
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  elfh_pkg::cmd_t                    cmd,
    output logic                              done,
    output elfh_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [elfh_pkg::TOTAL_W-1:0]      cfg_data
);

    localparam int unsigned AW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int unsigned LIMIT_SAT = (SYMBOL_LIMIT > 131071) ? 131071 : SYMBOL_LIMIT;
    localparam logic [elfh_pkg::WORD_W-1:0] LIMIT = elfh_pkg::WORD_W'(LIMIT_SAT);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_RDOUT = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [elfh_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [31:0]                    hash_reg, hash_next;
    logic [elfh_pkg::WORD_W-1:0]    syms_reg, syms_next;
    logic [elfh_pkg::COUNT_W-1:0]   buckets_reg, buckets_next;
    logic [elfh_pkg::HASH_W-1:0]    cur_hash_reg, cur_hash_next;
    logic [elfh_pkg::COUNT_W-1:0]   slot_reg, slot_next;
    logic                           err_reg, err_next;
    logic                           done_reg, done_next;
    elfh_pkg::result_t              result_reg, result_next;

    logic                           accept;
    logic [31:0]                    hash_shift;
    logic [elfh_pkg::COUNT_W-1:0]   new_buckets;
    elfh_pkg::mod_req_t             mod_req;
    logic                           mod_done;
    logic [elfh_pkg::COUNT_W-1:0]   mod_rem;
    elfh_pkg::store_ctl_t           st_ctl;
    logic [AW-1:0]                  st_addr;
    logic [elfh_pkg::WORD_W-1:0]    st_wdata;
    logic [elfh_pkg::WORD_W-1:0]    st_rdata;
    logic                           st_busy;

    assign accept      = start && (state_reg == ST_IDLE);
    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign hash_shift  = (hash_reg << 4) + {24'd0, cmd.name_byte};
    assign new_buckets = elfh_pkg::pick_buckets(total_reg, BUCKET_DEPTH);

    // Hold the symbol count register
    always_comb
    begin
        total_next = total_reg;
        if (cfg_valid && cfg_ready)
        begin
            total_next = cfg_data;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        hash_next     = hash_reg;
        syms_next     = syms_reg;
        buckets_next  = buckets_reg;
        cur_hash_next = cur_hash_reg;
        slot_next     = slot_reg;
        err_next      = err_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        mod_req       = '{go: 1'b0, dividend: hash_reg[elfh_pkg::HASH_W-1:0],
                          divisor: buckets_reg};
        st_ctl        = '{clear_go: 1'b0, rd_en: 1'b0, wr_en: 1'b0};
        st_addr       = AW'(slot_reg);
        st_wdata      = syms_reg + 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.func)
                        elfh_pkg::FUNC_BYTE:
                        begin
                            hash_next = hash_shift ^ {24'd0, hash_shift[31:28], 4'd0};
                        end
                        elfh_pkg::FUNC_END:
                        begin
                            cur_hash_next = hash_reg[elfh_pkg::HASH_W-1:0];
                            hash_next     = '0;
                            err_next      = (syms_reg >= {1'b0, total_reg}) ||
                                            (syms_reg >= LIMIT);
                            mod_req.go    = 1'b1;
                            state_next    = ST_DIV;
                        end
                        elfh_pkg::FUNC_READ:
                        begin
                            if ({3'd0, cmd.read_slot} >= buckets_reg)
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                                result_next.kind       = elfh_pkg::KIND_HEAD;
                                result_next.error_flag = 1'b1;
                            end
                            else
                            begin
                                st_ctl.rd_en = 1'b1;
                                st_addr      = AW'(cmd.read_slot);
                                state_next   = ST_RDOUT;
                            end
                        end
                        elfh_pkg::FUNC_START:
                        begin
                            hash_next       = '0;
                            syms_next       = '0;
                            buckets_next    = new_buckets;
                            st_ctl.clear_go = 1'b1;
                            done_next       = 1'b1;
                            result_next     = '0;
                            result_next.kind        = elfh_pkg::KIND_HEADER;
                            result_next.word_value  = {1'b0, new_buckets};
                            result_next.chain_total = {1'b0, total_reg} + 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                // Wait out the memory sweep
                if (!st_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    slot_next = mod_rem;
                    if (err_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        result_next.kind       = elfh_pkg::KIND_CHAIN;
                        result_next.hash_value = cur_hash_reg;
                        result_next.slot_used  = mod_rem[elfh_pkg::SLOT_W-1:0];
                        result_next.error_flag = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        st_ctl.rd_en = 1'b1;
                        st_addr      = AW'(mod_rem);
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                // Old head is already registered; advance to the update
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // Emit the old head and make this symbol the new head
                st_ctl.wr_en = 1'b1;
                syms_next    = syms_reg + 1'b1;
                done_next    = 1'b1;
                result_next  = '0;
                result_next.kind       = elfh_pkg::KIND_CHAIN;
                result_next.word_value = st_rdata;
                result_next.hash_value = cur_hash_reg;
                result_next.slot_used  = slot_reg[elfh_pkg::SLOT_W-1:0];
                state_next   = ST_IDLE;
            end
            ST_RDOUT:
            begin
                done_next   = 1'b1;
                result_next = '0;
                result_next.kind       = elfh_pkg::KIND_HEAD;
                result_next.word_value = st_rdata;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            total_reg   <= elfh_pkg::TOTAL_RESET;
            hash_reg    <= '0;
            syms_reg    <= '0;
            buckets_reg <= elfh_pkg::COUNT_W'(1);
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            hash_reg    <= hash_next;
            syms_reg    <= syms_next;
            buckets_reg <= buckets_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_hash_reg <= cur_hash_next;
        slot_reg     <= slot_next;
        err_reg      <= err_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    elfh_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    elfh_bucket_store #(
        .AW (AW)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (st_ctl),
        .addr        (st_addr),
        .wdata       (st_wdata),
        .clear_count (new_buckets),
        .rdata       (st_rdata),
        .busy        (st_busy)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for elf_sysv_hash_table_builder_top: a directed request table, then
// random symbol tables, checked against fixed results or a behavioral model of the table build.
// Depends on elfh_pkg and the builder RTL only.
module tb_top;

    localparam int unsigned DEPTH         = 4099;
    localparam int unsigned SYM_LIMIT     = 65535;
    localparam int unsigned RANDOM_REQS   = 950;
    localparam int unsigned QUIET_AFTER   = 800;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 64;

    typedef enum logic {ROW_REQ, ROW_CFG} row_act_t;

    typedef struct packed {
        row_act_t                      act;
        elfh_pkg::cmd_t                c;
        logic [elfh_pkg::TOTAL_W-1:0]  cfg_value;
        logic                          fixed;
        elfh_pkg::result_t             want;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    elfh_pkg::cmd_t               cmd;
    logic                         done;
    elfh_pkg::result_t            result;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [elfh_pkg::TOTAL_W-1:0] cfg_data;

    // Model of the table: register, hash, symbol count, bucket heads
    logic [15:0] total_m;
    logic [31:0] hash_acc_m;
    logic [16:0] symbols_m;
    logic [15:0] buckets_m;
    logic [16:0] heads_m [DEPTH];

    elfh_pkg::result_t results_due [$];
    stim_row_t         directed_rows [$];
    int unsigned       mismatches;
    int unsigned       random_reqs;

    elf_sysv_hash_table_builder_top #(
        .BUCKET_DEPTH (DEPTH),
        .SYMBOL_LIMIT (SYM_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stepped prime series for the bucket count
    function automatic int unsigned step_prime(input int i);
        unique case (i)
            0:       return 1;
            1:       return 3;
            2:       return 17;
            3:       return 37;
            4:       return 67;
            5:       return 97;
            6:       return 131;
            7:       return 197;
            8:       return 263;
            9:       return 521;
            10:      return 1031;
            11:      return 2053;
            12:      return 4099;
            13:      return 8209;
            14:      return 16411;
            default: return 32771;
        endcase
    endfunction

    // Largest prime the total reaches, never above the store depth
    function automatic logic [15:0] buckets_for(input logic [15:0] total);
        logic [15:0] n;
        n = 16'd1;
        for (int i = 1; i < 16; i++)
        begin
            if (32'(total) >= step_prime(i) && step_prime(i) <= DEPTH)
            begin
                n = 16'(step_prime(i));
            end
        end
        return n;
    endfunction

    task automatic reset_table_model();
        total_m    = elfh_pkg::TOTAL_RESET;
        hash_acc_m = '0;
        symbols_m  = '0;
        buckets_m  = 16'd1;
        for (int i = 0; i < DEPTH; i++)
        begin
            heads_m[i] = '0;
        end
    endtask

    // Apply one request to the model; returns 1 when it yields a result
    function automatic bit predict_table_step(input elfh_pkg::cmd_t c,
                                              output elfh_pkg::result_t r);
        logic [31:0] h;
        logic [15:0] bc;
        int unsigned slot;
        r = '0;
        if (c.func == elfh_pkg::FUNC_BYTE)
        begin
            // fold the top nibble back in, zero bytes included
            h = (hash_acc_m << 4) + 32'(c.name_byte);
            h ^= (h >> 24) & 32'h0000_00f0;
            hash_acc_m = h;
            return 1'b0;
        end
        if (c.func == elfh_pkg::FUNC_START)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                heads_m[i] = '0;
            end
            symbols_m     = '0;
            hash_acc_m    = '0;
            buckets_m     = buckets_for(total_m);
            r.kind        = elfh_pkg::KIND_HEADER;
            r.word_value  = elfh_pkg::WORD_W'(buckets_m);
            r.chain_total = elfh_pkg::WORD_W'(total_m) + 17'd1;
        end
        else if (c.func == elfh_pkg::FUNC_END)
        begin
            bc           = (buckets_m == 16'd0) ? 16'd1 : buckets_m;
            slot         = 32'(hash_acc_m[27:0] % 28'(bc));
            r.kind       = elfh_pkg::KIND_CHAIN;
            r.hash_value = hash_acc_m[27:0];
            r.slot_used  = elfh_pkg::SLOT_W'(slot);
            hash_acc_m   = '0;
            // symbol beyond the register value or the symbol limit: report, table untouched
            if (32'(symbols_m) >= 32'(total_m) || 32'(symbols_m) >= SYM_LIMIT ||
                slot >= DEPTH)
            begin
                r.error_flag = 1'b1;
            end
            else
            begin
                r.word_value  = heads_m[slot];
                symbols_m     = symbols_m + 17'd1;
                heads_m[slot] = symbols_m;
            end
        end
        else
        begin
            // bucket head read
            r.kind = elfh_pkg::KIND_HEAD;
            if (32'(c.read_slot) >= 32'(buckets_m) || 32'(c.read_slot) >= DEPTH)
            begin
                r.error_flag = 1'b1;
            end
            else
            begin
                r.word_value = heads_m[c.read_slot];
            end
        end
        return 1'b1;
    endfunction

    function automatic elfh_pkg::result_t outcome(input logic [1:0] kind,
                                                  input int unsigned word,
                                                  input int unsigned chains,
                                                  input int unsigned hash,
                                                  input int unsigned slot,
                                                  input logic err);
        elfh_pkg::result_t r;
        r.kind        = kind;
        r.word_value  = 17'(word);
        r.chain_total = 17'(chains);
        r.hash_value  = 28'(hash);
        r.slot_used   = 13'(slot);
        r.error_flag  = err;
        return r;
    endfunction

    function automatic stim_row_t req_row(input logic [1:0] func, input logic [7:0] b,
                                          input logic [12:0] slot, input logic fixed,
                                          input elfh_pkg::result_t want);
        stim_row_t row;
        row             = '0;
        row.act         = ROW_REQ;
        row.c.func      = func;
        row.c.name_byte = b;
        row.c.read_slot = slot;
        row.fixed       = fixed;
        row.want        = want;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [15:0] value);
        stim_row_t row;
        row           = '0;
        row.act       = ROW_CFG;
        row.cfg_value = value;
        return row;
    endfunction

    function automatic elfh_pkg::cmd_t random_cmd();
        elfh_pkg::cmd_t c;
        c.func      = 2'($urandom);
        c.name_byte = 8'($urandom);
        c.read_slot = 13'($urandom);
        return c;
    endfunction

    function automatic logic [15:0] pick_random_total();
        unique case ($urandom_range(0, 15))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2, 3, 4: return 16'($urandom_range(41, 600));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    // Present one request, hold until taken, then queue its expected result
    task automatic send_request(input elfh_pkg::cmd_t c, input logic fixed,
                                input elfh_pkg::result_t want);
        elfh_pkg::result_t predicted;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (predict_table_step(c, predicted))
        begin
            results_due.push_back(fixed ? want : predicted);
        end
    endtask

    task automatic sender_gap(input int unsigned cycles);
        start <= 1'b0;
        cmd   <= random_cmd();
        repeat (cycles) @(posedge clk);
    endtask

    // Drain all results and let the block go quiet
    task automatic wait_table_idle();
        start <= 1'b0;
        while (results_due.size() != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_symbol_total(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        total_m = value;
    endtask

    task automatic drive_random_request(input elfh_pkg::cmd_t c, input bit steady);
        if (!steady && random_reqs < QUIET_AFTER && $urandom_range(0, 3) == 0)
        begin
            sender_gap($urandom_range(1, 16));
        end
        send_request(c, 1'b0, '0);
        random_reqs++;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        elfh_pkg::result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with none expected: kind %0d word 0x%0h",
                       result.kind, result.word_value);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(result.kind));
                check_field("word_value", 32'(want.word_value), 32'(result.word_value));
                check_field("chain_total", 32'(want.chain_total), 32'(result.chain_total));
                check_field("hash_value", 32'(want.hash_value), 32'(result.hash_value));
                check_field("slot_used", 32'(want.slot_used), 32'(result.slot_used));
                check_field("error_flag", 32'(want.error_flag), 32'(result.error_flag));
            end
        end
    end

    initial
    begin
        #100000000;
        $display("[elf_sysv_hash_table_builder_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        elfh_pkg::cmd_t c;
        bit             steady;
        int unsigned    cap;
        int unsigned    n_names;
        int unsigned    name_len;

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        mismatches  = 0;
        random_reqs = 0;
        reset_table_model();

        // Reset state: one empty bucket, no start yet
        directed_rows.push_back(req_row(elfh_pkg::FUNC_READ, 8'h00, 13'd0, 1'b1,
                                outcome(elfh_pkg::KIND_HEAD, 0, 0, 0, 0, 1'b0)));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_READ, 8'hff, 13'h1fff, 1'b1,
                                outcome(elfh_pkg::KIND_HEAD, 0, 0, 0, 0, 1'b1)));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_READ, 8'h00, 13'd1, 1'b1,
                                outcome(elfh_pkg::KIND_HEAD, 0, 0, 0, 0, 1'b1)));
        // Empty name hashes to zero
        directed_rows.push_back(req_row(elfh_pkg::FUNC_END, 8'h00, 13'd0, 1'b1,
                                outcome(elfh_pkg::KIND_CHAIN, 0, 0, 0, 0, 1'b0)));
        // Long name with byte extremes to drive the high-nibble fold
        directed_rows.push_back(req_row(elfh_pkg::FUNC_BYTE, 8'h00, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_BYTE, 8'hff, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_BYTE, 8'h80, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_BYTE, 8'h7f, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_BYTE, 8'hff, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_BYTE, 8'hff, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_BYTE, 8'hff, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_END, 8'h00, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_READ, 8'h00, 13'd0, 1'b0, '0));
        // Zero symbols: smallest table, every symbol overflows
        directed_rows.push_back(cfg_row(16'd0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_START, 8'h00, 13'd0, 1'b1,
                                outcome(elfh_pkg::KIND_HEADER, 1, 1, 0, 0, 1'b0)));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_END, 8'h00, 13'd0, 1'b1,
                                outcome(elfh_pkg::KIND_CHAIN, 0, 0, 0, 0, 1'b1)));
        // Largest register value: bucket count capped at the store depth
        directed_rows.push_back(cfg_row(16'hffff));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_START, 8'h00, 13'd0, 1'b1,
                                outcome(elfh_pkg::KIND_HEADER, 4099, 65536, 0, 0, 1'b0)));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_BYTE, 8'h61, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_END, 8'h00, 13'd0, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_READ, 8'h00, 13'd4098, 1'b0, '0));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_READ, 8'h00, 13'd4099, 1'b1,
                                outcome(elfh_pkg::KIND_HEAD, 0, 0, 0, 0, 1'b1)));
        // Register lowered mid-table: the limit check follows the new value
        directed_rows.push_back(cfg_row(16'd1));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_END, 8'h00, 13'd0, 1'b1,
                                outcome(elfh_pkg::KIND_CHAIN, 0, 0, 0, 0, 1'b1)));
        directed_rows.push_back(cfg_row(16'd3));
        directed_rows.push_back(req_row(elfh_pkg::FUNC_START, 8'h00, 13'd0, 1'b1,
                                outcome(elfh_pkg::KIND_HEADER, 3, 4, 0, 0, 1'b0)));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].act == ROW_CFG)
            begin
                wait_table_idle();
                write_symbol_total(directed_rows[i].cfg_value);
            end
            else
            begin
                send_request(directed_rows[i].c, directed_rows[i].fixed, directed_rows[i].want);
            end
        end

        // Random tables: optional register change, start, names with reads and noise
        while (random_reqs < RANDOM_REQS)
        begin
            steady = ($urandom_range(0, 2) == 0);
            if (random_reqs < QUIET_AFTER && $urandom_range(0, 3) != 0)
            begin
                wait_table_idle();
                write_symbol_total(pick_random_total());
            end
            if ($urandom_range(0, 5) != 0)
            begin
                c      = random_cmd();
                c.func = elfh_pkg::FUNC_START;
                drive_random_request(c, steady);
            end
            // small totals get a few extra names to overflow the table
            cap     = (total_m <= 16'd16) ? 32'(total_m) + 3 : 16;
            n_names = $urandom_range(1, cap);
            for (int s = 0; s < n_names; s++)
            begin
                if (random_reqs >= RANDOM_REQS)
                begin
                    break;
                end
                name_len = $urandom_range(0, 9);
                for (int b = 0; b < name_len; b++)
                begin
                    c      = random_cmd();
                    c.func = elfh_pkg::FUNC_BYTE;
                    drive_random_request(c, steady);
                end
                c      = random_cmd();
                c.func = elfh_pkg::FUNC_END;
                drive_random_request(c, steady);
                if ($urandom_range(0, 2) == 0)
                begin
                    c      = random_cmd();
                    c.func = elfh_pkg::FUNC_READ;
                    if ($urandom_range(0, 4) != 0)
                    begin
                        c.read_slot = 13'($urandom_range(0, 32'(buckets_m) - 1));
                    end
                    drive_random_request(c, steady);
                end
                if ($urandom_range(0, 15) == 0)
                begin
                    drive_random_request(random_cmd(), steady);
                end
                // hold off until the block has drained
                if (random_reqs < QUIET_AFTER && $urandom_range(0, 11) == 0)
                begin
                    wait_table_idle();
                end
            end
        end

        start <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("[elf_sysv_hash_table_builder_top] OK");
        end
        else
        begin
            $display("[elf_sysv_hash_table_builder_top] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/elfh_pkg.sv
hdl/elfh_mod_unit.sv
hdl/elfh_bucket_store.sv
hdl/elf_sysv_hash_table_builder_top.sv
tb/sv/tb_top.sv
